/* hdl/bs3_pkg.sv */
package bs3_pkg;

    // Sample and arithmetic widths (signed Q7.8 samples)
    localparam int SAMPLE_W = 16;
    localparam int COL_W    = 18;                     // sum of one 3-high column
    localparam int SUM_W    = 20;                     // sum of up to nine samples
    localparam int RECIP_W  = 17;                     // reciprocal, unsigned 1.16
    localparam int PROD_W   = SUM_W + RECIP_W + 1;
    localparam int FRAC_W   = 16;

    // Configuration registers
    localparam int MAP_WIDTH_W  = 11;
    localparam int MAP_HEIGHT_W = 13;
    localparam int ROW_W        = 13;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 13;

    localparam logic [CFG_INDEX_W-1:0]  REG_MAP_WIDTH    = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0]  REG_MAP_HEIGHT   = CFG_INDEX_W'(1);
    localparam logic [MAP_WIDTH_W-1:0]  MAP_WIDTH_RESET  = MAP_WIDTH_W'(64);
    localparam logic [MAP_HEIGHT_W-1:0] MAP_HEIGHT_RESET = MAP_HEIGHT_W'(64);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Front stage to window stage
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;      // zero outside the grid
        logic                upper_ok;    // row two back lies in the grid
        logic                emit_edge;   // right-edge point of the previous row
        logic                emit_inner;  // inner point of the current row
        logic                col1_ok;     // left column of the window counts
        logic [1:0]          nrows;
        logic [1:0]          ncols;
        logic                last;
    } bs3_cmd_t;

    // Queue entry: masked column sums plus divisor info
    typedef struct packed {
        logic [COL_W-1:0] term_a;
        logic [COL_W-1:0] term_b;
        logic [COL_W-1:0] term_c;
        logic [1:0]       nrows;
        logic [1:0]       ncols;
        logic             last;
    } bs3_entry_t;

    // round(65536 / n) for the neighborhood sizes that occur
    function automatic logic [RECIP_W-1:0] recip_of(input logic [1:0] nrows,
                                                    input logic [1:0] ncols);
        logic [3:0] n;
        n = {2'b00, nrows} * {2'b00, ncols};
        unique case (n)
            4'd1:    recip_of = RECIP_W'(65536);
            4'd2:    recip_of = RECIP_W'(32768);
            4'd3:    recip_of = RECIP_W'(21845);
            4'd4:    recip_of = RECIP_W'(16384);
            4'd6:    recip_of = RECIP_W'(10923);
            4'd9:    recip_of = RECIP_W'(7282);
            default: recip_of = '0;
        endcase
    endfunction

endpackage

/* hdl/bs3_front.sv */
module bs3_front #(
    parameter int MAX_WIDTH = 1024,
    localparam int ADDR_W = $clog2(MAX_WIDTH)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bs3_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bs3_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               sample_valid,
    output logic                               sample_ready,
    input  logic [bs3_pkg::SAMPLE_W-1:0]       height_sample,
    input  logic                               is_pad,
    input  logic [bs3_pkg::QCNT_W-1:0]         queue_count,
    output logic                               rd_en,
    output logic [ADDR_W-1:0]                  rd_addr,
    output logic                               cmd_valid,
    output bs3_pkg::bs3_cmd_t                  cmd,
    output logic [ADDR_W-1:0]                  cmd_addr
);

    localparam int WCMP_W = ($clog2(MAX_WIDTH + 1) > bs3_pkg::MAP_WIDTH_W)
                          ? $clog2(MAX_WIDTH + 1) : bs3_pkg::MAP_WIDTH_W;
    localparam int ROW_W  = bs3_pkg::ROW_W;

    logic                                run_reg;
    logic [bs3_pkg::MAP_WIDTH_W-1:0]     map_width_reg;
    logic [bs3_pkg::MAP_HEIGHT_W-1:0]    map_height_reg;
    logic [ADDR_W-1:0]                   col_reg, col_next;
    logic [ROW_W-1:0]                    row_reg, row_next;
    logic                                cmd_valid_reg, cmd_valid_next;
    bs3_pkg::bs3_cmd_t                   cmd_reg, cmd_next;
    logic [ADDR_W-1:0]                   cmd_addr_reg;

    logic [WCMP_W-1:0]                   w_raw, w_eff, col_inc;
    logic [ROW_W-1:0]                    h_eff;
    logic [ROW_W:0]                      row_ext, h_ext, row_inc;
    logic                                cfg_accept, cfg_hit, accept, take;
    logic                                in_grid, emit_edge, emit_inner, last, wrap, restart;

    assign cfg_ready  = run_reg;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign cfg_hit    = cfg_accept && ((cfg_index == bs3_pkg::REG_MAP_WIDTH) ||
                                       (cfg_index == bs3_pkg::REG_MAP_HEIGHT));

    // room for this beat and the one in the window stage
    assign sample_ready = run_reg &&
        (({1'b0, queue_count} + (bs3_pkg::QCNT_W + 1)'(cmd_valid_reg)) <
         (bs3_pkg::QCNT_W + 1)'(bs3_pkg::QUEUE_DEPTH));
    assign accept = sample_valid && sample_ready;

    always_comb
    begin
        w_raw = WCMP_W'(map_width_reg);
        if (w_raw == '0)
            w_eff = WCMP_W'(1);
        else if (w_raw > WCMP_W'(MAX_WIDTH))
            w_eff = WCMP_W'(MAX_WIDTH);
        else
            w_eff = w_raw;

        if (map_height_reg == '0)
            h_eff = ROW_W'(1);
        else if (map_height_reg > ROW_W'(bs3_pkg::HEIGHT_LIMIT))
            h_eff = ROW_W'(bs3_pkg::HEIGHT_LIMIT);
        else
            h_eff = map_height_reg;

        row_ext    = {1'b0, row_reg};
        h_ext      = {1'b0, h_eff};
        in_grid    = row_reg < h_eff;
        take       = accept && !(in_grid && is_pad);   // pad inside the grid is dropped
        emit_edge  = (col_reg == '0) && (row_reg >= ROW_W'(2));
        emit_inner = (col_reg != '0) && (row_reg != '0);
        last       = emit_edge && (row_ext == h_ext + (ROW_W + 1)'(1));
        col_inc    = WCMP_W'(col_reg) + WCMP_W'(1);
        wrap       = col_inc >= w_eff;
        row_inc    = row_ext + (ROW_W + 1)'(wrap);
        restart    = last || (row_inc > h_ext + (ROW_W + 1)'(1));

        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (take)
        begin
            if (restart)
            begin
                col_next = '0;
                row_next = '0;
            end
            else
            begin
                col_next = wrap ? '0 : col_inc[ADDR_W-1:0];
                row_next = row_inc[ROW_W-1:0];
            end
        end

        cmd_valid_next      = take;
        cmd_next.sample     = in_grid ? height_sample : '0;
        cmd_next.upper_ok   = row_reg >= ROW_W'(2);
        cmd_next.emit_edge  = emit_edge;
        cmd_next.emit_inner = emit_inner;
        cmd_next.last       = last;
        if (emit_edge)
        begin
            cmd_next.col1_ok = w_eff >= WCMP_W'(2);
            cmd_next.nrows   = 2'd1 + 2'(row_reg >= ROW_W'(3)) + 2'(row_reg <= h_eff);
            cmd_next.ncols   = 2'd1 + 2'(w_eff >= WCMP_W'(2));
        end
        else
        begin
            cmd_next.col1_ok = col_reg >= ADDR_W'(2);
            cmd_next.nrows   = 2'd1 + 2'(row_reg >= ROW_W'(2)) + 2'(row_reg < h_eff);
            cmd_next.ncols   = 2'd2 + 2'(col_reg >= ADDR_W'(2));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg        <= 1'b0;
            map_width_reg  <= bs3_pkg::MAP_WIDTH_RESET;
            map_height_reg <= bs3_pkg::MAP_HEIGHT_RESET;
            col_reg        <= '0;
            row_reg        <= '0;
            cmd_valid_reg  <= 1'b0;
        end
        else
        begin
            run_reg       <= 1'b1;
            col_reg       <= col_next;
            row_reg       <= row_next;
            cmd_valid_reg <= cmd_valid_next;
            if (cfg_accept && (cfg_index == bs3_pkg::REG_MAP_WIDTH))
                map_width_reg <= cfg_data[bs3_pkg::MAP_WIDTH_W-1:0];
            if (cfg_accept && (cfg_index == bs3_pkg::REG_MAP_HEIGHT))
                map_height_reg <= cfg_data[bs3_pkg::MAP_HEIGHT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg      <= cmd_next;
            cmd_addr_reg <= col_reg;
        end
    end

    assign rd_en     = take;
    assign rd_addr   = col_reg;
    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;
    assign cmd_addr  = cmd_addr_reg;

endmodule

/* hdl/bs3_window.sv */
module bs3_window #(
    parameter int MAX_WIDTH = 1024,
    localparam int ADDR_W = $clog2(MAX_WIDTH)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    input  logic                  cmd_valid,
    input  bs3_pkg::bs3_cmd_t     cmd,
    input  logic [ADDR_W-1:0]     cmd_addr,
    output logic                  push,
    output bs3_pkg::bs3_entry_t   push_entry
);

    localparam int SAMPLE_W = bs3_pkg::SAMPLE_W;
    localparam int COL_W    = bs3_pkg::COL_W;
    localparam int PAIR_W   = 2 * SAMPLE_W;
    localparam int EXT_W    = COL_W - SAMPLE_W;

    // per column: {two rows back, one row back}
    logic [PAIR_W-1:0]   row_store_mem [MAX_WIDTH];
    logic [PAIR_W-1:0]   rd_data_reg;
    logic [PAIR_W-1:0]   byp_data_reg;
    logic                byp_hit_reg;
    logic [COL_W-1:0]    col1_reg, col2_reg;

    logic [PAIR_W-1:0]   pair, wr_data;
    logic [SAMPLE_W-1:0] upper, middle, upper_term;
    logic [COL_W-1:0]    new_col;

    always_comb
    begin
        pair       = byp_hit_reg ? byp_data_reg : rd_data_reg;
        upper      = pair[PAIR_W-1:SAMPLE_W];
        middle     = pair[SAMPLE_W-1:0];
        upper_term = cmd.upper_ok ? upper : '0;
        new_col    = {{EXT_W{upper_term[SAMPLE_W-1]}}, upper_term}
                   + {{EXT_W{middle[SAMPLE_W-1]}}, middle}
                   + {{EXT_W{cmd.sample[SAMPLE_W-1]}}, cmd.sample};
        wr_data    = {middle, cmd.sample};

        push              = cmd_valid && (cmd.emit_edge || cmd.emit_inner);
        push_entry.term_a = cmd.col1_ok ? col1_reg : '0;
        push_entry.term_b = col2_reg;
        push_entry.term_c = cmd.emit_inner ? new_col : '0;
        push_entry.nrows  = cmd.nrows;
        push_entry.ncols  = cmd.ncols;
        push_entry.last   = cmd.last;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid)
            row_store_mem[cmd_addr] <= wr_data;
        if (rd_en)
        begin
            rd_data_reg  <= row_store_mem[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    // same column read while it is written (one-wide grid)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_hit_reg <= 1'b0;
            col1_reg    <= '0;
            col2_reg    <= '0;
        end
        else
        begin
            if (rd_en)
                byp_hit_reg <= cmd_valid && (rd_addr == cmd_addr);
            if (cmd_valid)
            begin
                col1_reg <= col2_reg;
                col2_reg <= new_col;
            end
        end
    end

endmodule

/* hdl/bs3_queue.sv */
module bs3_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  bs3_pkg::bs3_entry_t           push_entry,
    input  logic                          pop,
    output logic                          head_valid,
    output bs3_pkg::bs3_entry_t           head_entry,
    output logic [bs3_pkg::QCNT_W-1:0]    count
);

    localparam int DEPTH  = bs3_pkg::QUEUE_DEPTH;
    localparam int PTR_W  = bs3_pkg::QPTR_W;
    localparam int CNT_W  = bs3_pkg::QCNT_W;

    bs3_pkg::bs3_entry_t  q_mem [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= push_entry;
    end

    assign head_valid = count_reg != '0;
    assign head_entry = q_mem[rd_ptr_reg];
    assign count      = count_reg;

endmodule

/* hdl/bs3_mean.sv */
module bs3_mean (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            head_valid,
    input  bs3_pkg::bs3_entry_t             head_entry,
    output logic                            pop,
    output logic                            result_valid,
    input  logic                            result_ready,
    output logic [bs3_pkg::SAMPLE_W-1:0]    smoothed_height,
    output logic                            last_point
);

    localparam int SAMPLE_W = bs3_pkg::SAMPLE_W;
    localparam int COL_W    = bs3_pkg::COL_W;
    localparam int SUM_W    = bs3_pkg::SUM_W;
    localparam int RECIP_W  = bs3_pkg::RECIP_W;
    localparam int PROD_W   = bs3_pkg::PROD_W;
    localparam int FRAC_W   = bs3_pkg::FRAC_W;
    localparam int EXT_W    = SUM_W - COL_W;
    localparam int SCALED_W = PROD_W + 1 - FRAC_W;
    localparam int TOP_W    = SCALED_W - SAMPLE_W + 1;

    logic                       advance;
    logic                       b1_valid_reg, b2_valid_reg, out_valid_reg;
    logic [SUM_W-1:0]           b1_sum_reg, sum_next;
    logic [RECIP_W-1:0]         b1_recip_reg;
    logic                       b1_last_reg, b2_last_reg, last_reg;
    logic signed [PROD_W-1:0]   b2_prod_reg, prod_next;
    logic [SAMPLE_W-1:0]        smoothed_reg, sat_next;
    logic [PROD_W:0]            rounded;
    logic [SCALED_W-1:0]        scaled;
    logic [TOP_W-1:0]           top_bits;

    assign advance = !out_valid_reg || result_ready;
    assign pop     = advance && head_valid;

    always_comb
    begin
        sum_next = {{EXT_W{head_entry.term_a[COL_W-1]}}, head_entry.term_a}
                 + {{EXT_W{head_entry.term_b[COL_W-1]}}, head_entry.term_b}
                 + {{EXT_W{head_entry.term_c[COL_W-1]}}, head_entry.term_c};

        prod_next = $signed(b1_sum_reg) * $signed({1'b0, b1_recip_reg});

        // add one half, floor by dropping the fraction, then clamp
        rounded  = {b2_prod_reg[PROD_W-1], b2_prod_reg} + (PROD_W + 1)'(1 << (FRAC_W - 1));
        scaled   = rounded[PROD_W:FRAC_W];
        top_bits = scaled[SCALED_W-1:SAMPLE_W-1];
        if ((&top_bits) || !(|top_bits))
            sat_next = scaled[SAMPLE_W-1:0];
        else
            sat_next = {scaled[SCALED_W-1], {(SAMPLE_W - 1){~scaled[SCALED_W-1]}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b1_valid_reg  <= head_valid;
            b2_valid_reg  <= b1_valid_reg;
            out_valid_reg <= b2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b1_sum_reg   <= sum_next;
            b1_recip_reg <= bs3_pkg::recip_of(head_entry.nrows, head_entry.ncols);
            b1_last_reg  <= head_entry.last;
            b2_prod_reg  <= prod_next;
            b2_last_reg  <= b1_last_reg;
            smoothed_reg <= sat_next;
            last_reg     <= b2_last_reg;
        end
    end

    assign result_valid    = out_valid_reg;
    assign smoothed_height = smoothed_reg;
    assign last_point      = last_reg;

endmodule

/* hdl/box_smooth_3x3.sv */
// box_smooth_3x3: 3x3 box mean over a raster height grid.
//
// Sample channel: one beat per grid point in raster order (height_sample,
// signed Q7.8). After the last row, pad beats (is_pad = 1) flush the window;
// map_width + 1 of them bring out the final row. Pads inside the grid are
// dropped. Result channel: one beat per grid point, the mean of its in-grid
// neighbors (1, 2, 3, 4, 6 or 9 samples), rounded to nearest and saturated;
// last_point marks the final point, after which the next frame starts.
// Config channel: index 0 = map_width, 1 = map_height; a write restarts the
// frame. Write only while idle. cfg_ready is high whenever out of reset.
//
// Throughput: one sample per cycle unless the queue backs up; the row store
// has one read and one write port, and each beat uses one of each. The
// result for grid point k arrives with sample beat k + map_width + 1 and then
// passes the command, queue, sum, product and output registers in order.
// Reset: width and height 64, position at the first point, no store clear.
// A stalled result holds; a 4-entry queue between the window stage and the
// multiply pipe absorbs it, and sample_ready drops before it can overflow.
module box_smooth_3x3 #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bs3_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bs3_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              sample_valid,
    output logic                              sample_ready,
    input  logic [bs3_pkg::SAMPLE_W-1:0]      height_sample,
    input  logic                              is_pad,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic [bs3_pkg::SAMPLE_W-1:0]      smoothed_height,
    output logic                              last_point
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);

    // front: position tracking, row store read issue
    logic                          rd_en;
    logic [ADDR_W-1:0]             rd_addr;
    logic                          cmd_valid;
    bs3_pkg::bs3_cmd_t             cmd;
    logic [ADDR_W-1:0]             cmd_addr;

    // window stage to queue
    logic                          push;
    bs3_pkg::bs3_entry_t           push_entry;

    // queue to back
    logic                          pop;
    logic                          head_valid;
    bs3_pkg::bs3_entry_t           head_entry;
    logic [bs3_pkg::QCNT_W-1:0]    queue_count;

    bs3_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sample_valid  (sample_valid),
        .sample_ready  (sample_ready),
        .height_sample (height_sample),
        .is_pad        (is_pad),
        .queue_count   (queue_count),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_addr      (cmd_addr)
    );

    // row store, column sums, forwarding for a one-wide grid
    bs3_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_addr   (cmd_addr),
        .push       (push),
        .push_entry (push_entry)
    );

    bs3_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .count      (queue_count)
    );

    // back: sum, multiply by reciprocal, round and clamp
    bs3_mean u_mean (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (head_valid),
        .head_entry      (head_entry),
        .pop             (pop),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .smoothed_height (smoothed_height),
        .last_point      (last_point)
    );

endmodule

/* hdl/bs3_chk.sv */
module bs3_chk (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic [bs3_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input logic [bs3_pkg::CFG_DATA_W-1:0]    cfg_data,
    input logic                              sample_valid,
    input logic                              sample_ready,
    input logic [bs3_pkg::SAMPLE_W-1:0]      height_sample,
    input logic                              is_pad,
    input logic                              result_valid,
    input logic                              result_ready,
    input logic [bs3_pkg::SAMPLE_W-1:0]      smoothed_height,
    input logic                              last_point
);

    logic        s_acc, r_acc;
    logic [31:0] gap_reg, gap_next;

    assign s_acc = sample_valid && sample_ready;
    assign r_acc = result_valid && result_ready;

    // accepted samples not yet matched by a result beat
    always_comb
    begin
        gap_next = gap_reg + 32'(s_acc) - 32'(r_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gap_reg <= '0;
        else
            gap_reg <= gap_next;
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(smoothed_height) && $stable(last_point))
        else $error("result beat changed while stalled");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !result_valid && !sample_ready && !cfg_ready)
        else $error("handshake active during reset");

    a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
        r_acc |-> gap_reg != '0)
        else $error("result beat without an earlier sample beat");

    a_cfg_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
        last_point && result_valid |-> gap_reg != '0)
        else $error("last point shown with no sample behind it");

endmodule

bind box_smooth_3x3 bs3_chk u_bs3_chk (.*);

/* tb/sv/box_smooth_3x3_check.sv */
`timescale 1ns / 1ps

module box_smooth_3x3_check #(
    parameter int MAX_COLS = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [bs3_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bs3_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             sample_valid,
    input  logic                             sample_ready,
    input  logic [bs3_pkg::SAMPLE_W-1:0]     height_sample,
    input  logic                             is_pad,
    input  logic                             result_valid,
    input  logic                             result_ready,
    input  logic [bs3_pkg::SAMPLE_W-1:0]     smoothed_height,
    input  logic                             last_point,
    output int                               mismatches,
    output int                               pending
);
    import bs3_pkg::*;

    typedef struct packed {
        logic [SAMPLE_W-1:0] height;
        logic                last;
    } smoothed_t;

    smoothed_t                  smoothed_due[$];
    logic [MAP_WIDTH_W-1:0]     width_reg;
    logic [MAP_HEIGHT_W-1:0]    rows_reg;
    logic signed [SAMPLE_W-1:0] row_two_back [MAX_COLS];
    logic signed [SAMPLE_W-1:0] row_one_back [MAX_COLS];
    logic signed [SAMPLE_W-1:0] win [3][3];
    int unsigned                col_pos;
    int unsigned                row_pos;
    int                         errors = 0;

    function automatic int unsigned cols_in_use();
        if (width_reg == 0)
            return 1;
        if (width_reg > MAX_COLS)
            return MAX_COLS;
        return width_reg;
    endfunction

    function automatic int unsigned rows_in_use();
        if (rows_reg == 0)
            return 1;
        if (rows_reg > HEIGHT_LIMIT)
            return HEIGHT_LIMIT;
        return rows_reg;
    endfunction

    // 1.16 reciprocal of the neighbor count
    function automatic longint inverse_count(input int n);
        case (n)
            1:       return 65536;
            2:       return 32768;
            3:       return 21845;
            4:       return 16384;
            6:       return 10923;
            9:       return 7282;
            default: return 0;
        endcase
    endfunction

    // Mean around point (pr, pc); window column cj holds column pc.
    function automatic logic [SAMPLE_W-1:0] box_mean(input int pr, input int pc, input int cj,
                                                     input int w, input int h);
        longint acc;
        longint scaled;
        int     n;
        int     i;
        int     j;
        int     col;
        acc = 0;
        n   = 0;
        for (i = 0; i < 3; i++) begin
            if (pr + i - 1 < 0 || pr + i - 1 >= h)
                continue;
            for (j = 0; j < 3; j++) begin
                col = pc + j - cj;
                if (j - cj < -1 || j - cj > 1 || col < 0 || col >= w)
                    continue;
                acc += win[i][j];
                n++;
            end
        end
        scaled = (acc * inverse_count(n) + 32768) >>> 16;
        if (scaled > 32767)
            scaled = 32767;
        if (scaled < -32768)
            scaled = -32768;
        return scaled[SAMPLE_W-1:0];
    endfunction

    task automatic flag_miss(input string what);
        errors++;
        if (errors <= 10)
            $display("[%0t] smooth mismatch: %s", $time, what);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        if (idx == REG_MAP_WIDTH)
            width_reg = data[MAP_WIDTH_W-1:0];
        else if (idx == REG_MAP_HEIGHT)
            rows_reg = data[MAP_HEIGHT_W-1:0];
        else
            return;
        col_pos = 0;
        row_pos = 0;
    endtask

    task automatic take_sample(input logic [SAMPLE_W-1:0] raw, input logic pad);
        int unsigned                w;
        int unsigned                h;
        int unsigned                r;
        int unsigned                c;
        int                         i;
        logic signed [SAMPLE_W-1:0] s;
        smoothed_t                  res;
        logic                       have;
        logic                       done;
        w = cols_in_use();
        h = rows_in_use();
        r = row_pos;
        c = col_pos % w;
        if (r < h && pad)
            return;
        s    = (r < h) ? raw : '0;
        have = 1'b0;
        res  = '0;
        // right-edge point of the row before, from the window before the shift
        if (c == 0 && r >= 2) begin
            res.height = box_mean(r - 2, w - 1, 2, w, h);
            res.last   = (r - 2 == h - 1);
            have       = 1'b1;
        end
        for (i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2]       = row_two_back[c];
        win[1][2]       = row_one_back[c];
        win[2][2]       = s;
        row_two_back[c] = row_one_back[c];
        row_one_back[c] = s;
        if (c >= 1 && r >= 1) begin
            res.height = box_mean(r - 1, c - 1, 1, w, h);
            res.last   = (r - 1 == h - 1) && (c - 1 == w - 1);
            have       = 1'b1;
        end
        if (have)
            smoothed_due.push_back(res);
        done = have && res.last;
        c++;
        if (c >= w) begin
            c = 0;
            r++;
        end
        if (done || r > h + 1) begin
            c = 0;
            r = 0;
        end
        col_pos = c % 1024;
        row_pos = r % 8192;
    endtask

    task automatic check_result(input logic [SAMPLE_W-1:0] got_h, input logic got_last);
        smoothed_t want;
        if (smoothed_due.size() == 0) begin
            flag_miss($sformatf("unexpected result height %0d last %0b",
                                $signed(got_h), got_last));
            return;
        end
        want = smoothed_due.pop_front();
        if (got_h !== want.height)
            flag_miss($sformatf("height expected %0d got %0d",
                                $signed(want.height), $signed(got_h)));
        if (got_last !== want.last)
            flag_miss($sformatf("last_point expected %0b got %0b", want.last, got_last));
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            width_reg = MAP_WIDTH_RESET;
            rows_reg  = MAP_HEIGHT_RESET;
            col_pos   = 0;
            row_pos   = 0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    win[i][j] = '0;
            for (int k = 0; k < MAX_COLS; k++) begin
                row_two_back[k] = '0;
                row_one_back[k] = '0;
            end
            smoothed_due.delete();
            mismatches <= 0;
            pending    <= 0;
        end
        else begin
            if (result_valid && result_ready)
                check_result(smoothed_height, last_point);
            if (cfg_valid && cfg_ready)
                write_reg(cfg_index, cfg_data);
            if (sample_valid && sample_ready)
                take_sample(height_sample, is_pad);
            mismatches <= errors;
            pending    <= smoothed_due.size();
        end
    end

endmodule

/* tb/sv/box_smooth_3x3_tb.sv */
`timescale 1ns / 1ps

// Stimulus and verdict for box_smooth_3x3. Prediction and comparison live in
// box_smooth_3x3_check, which sits beside the block and watches all three
// channels; this module only drives beats and reads back its counters.
module box_smooth_3x3_tb;
    import bs3_pkg::*;

    localparam int MAX_COLS      = 1024;
    localparam int GAP_MAX       = 18;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;   // long result back-pressure
    localparam int RANDOM_ITEMS  = 1800;
    localparam int CYCLE_LIMIT   = 2_000_000;

    // indexes past the register map; writes there must be dropped
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = CFG_INDEX_W'(3);

    localparam logic [SAMPLE_W-1:0] TOP_HEIGHT    = 16'h7fff;
    localparam logic [SAMPLE_W-1:0] BOTTOM_HEIGHT = 16'h8000;
    localparam logic [SAMPLE_W-1:0] MINUS_ONE     = 16'hffff;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;
    logic                   sample_valid  = 1'b0;
    logic                   sample_ready;
    logic [SAMPLE_W-1:0]    height_sample = '0;
    logic                   is_pad        = 1'b0;
    logic                   result_valid;
    logic                   result_ready  = 1'b0;
    logic [SAMPLE_W-1:0]    smoothed_height;
    logic                   last_point;

    int   mismatches;
    int   pending;
    int   cycles        = 0;
    int   cur_w         = 64;   // grid size in force, after clamping
    int   cur_h         = 64;
    int   fed_items     = 0;    // beats that moved the grid position
    logic send_burst    = 1'b0; // stretches with no idling, per side
    logic sink_burst    = 1'b0;
    logic hold_results  = 1'b0; // asks the result side for one long stall

    box_smooth_3x3 #(
        .MAX_WIDTH(MAX_COLS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .sample_valid   (sample_valid),
        .sample_ready   (sample_ready),
        .height_sample  (height_sample),
        .is_pad         (is_pad),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .smoothed_height(smoothed_height),
        .last_point     (last_point)
    );

    box_smooth_3x3_check #(
        .MAX_COLS(MAX_COLS)
    ) u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .sample_valid   (sample_valid),
        .sample_ready   (sample_ready),
        .height_sample  (height_sample),
        .is_pad         (is_pad),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .smoothed_height(smoothed_height),
        .last_point     (last_point),
        .mismatches     (mismatches),
        .pending        (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Idle cycles ahead of one beat: mostly short, sometimes up to the max,
    // none at all inside a burst stretch.
    function automatic int pick_gap(input logic burst);
        if (burst)
            return 0;
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, GAP_MAX);
        return $urandom_range(0, 2);
    endfunction

    // Sample values lean on the extremes so saturation and rounding both show.
    function automatic logic [SAMPLE_W-1:0] pick_height();
        case ($urandom_range(0, 9))
            0:       return TOP_HEIGHT;
            1:       return BOTTOM_HEIGHT;
            2:       return '0;
            3:       return MINUS_ONE;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Mostly small grid sizes, with zero (taken as one) in the mix.
    function automatic logic [CFG_DATA_W-1:0] pick_dim(input int upper);
        case ($urandom_range(0, 9))
            0:       return CFG_DATA_W'(0);
            1:       return CFG_DATA_W'(1);
            2:       return CFG_DATA_W'(2);
            3:       return CFG_DATA_W'(3);
            default: return CFG_DATA_W'($urandom_range(1, upper));
        endcase
    endfunction

    function automatic int width_in_use(input logic [CFG_DATA_W-1:0] data);
        int v;
        v = data[MAP_WIDTH_W-1:0];
        if (v == 0)
            return 1;
        return (v > MAX_COLS) ? MAX_COLS : v;
    endfunction

    function automatic int rows_in_use(input logic [CFG_DATA_W-1:0] data);
        int v;
        v = data[MAP_HEIGHT_W-1:0];
        if (v == 0)
            return 1;
        return (v > HEIGHT_LIMIT) ? HEIGHT_LIMIT : v;
    endfunction

    // Whole grid plus the width+1 flush beats that bring out the last row.
    function automatic int frame_items();
        return cur_w * cur_h + cur_w + 1;
    endfunction

    // One sample beat. Valid stays up between back-to-back beats, so it gets
    // only one assignment per edge; it drops only ahead of an idle gap.
    task automatic send_beat(input logic [SAMPLE_W-1:0] value, input logic pad);
        int gap;
        if ($urandom_range(0, 99) == 0)
            send_burst = !send_burst;
        gap = pick_gap(send_burst);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid  <= 1'b1;
        height_sample <= value;
        is_pad        <= pad;
        do @(posedge clk); while (!sample_ready);
    endtask

    // Stop sending and wait until every due result is out, then give the
    // pipe a few more cycles for beats that produce nothing. Rechecked after
    // the pause since a beat taken on the entry edge is not yet counted.
    task automatic settle();
        sample_valid <= 1'b0;
        do
        begin
            while (pending != 0) @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
        while (pending != 0);
    endtask

    // Config beat; valid is left high so a following write goes back to back.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // New grid size, written only once the block has gone quiet. Each size write
    // restarts the frame; now and then a spare-index write, ignored, rides along.
    task automatic configure(input logic [CFG_DATA_W-1:0] wdata,
                             input logic [CFG_DATA_W-1:0] hdata,
                             input logic spare);
        settle();
        write_reg(REG_MAP_WIDTH, wdata);
        write_reg(REG_MAP_HEIGHT, hdata);
        if (spare)
            write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                      CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        cur_w = width_in_use(wdata);
        cur_h = rows_in_use(hdata);
    endtask

    // Random-content frame of 'stop' grid/flush beats. Noisy frames slip in
    // pads inside the grid (dropped by the block) and real samples during
    // the flush (treated as pads). pause_at >= 0 drains mid-frame.
    task automatic run_frame(input int stop, input logic noisy, input int pause_at);
        int k;
        for (k = 0; k < stop; k++)
        begin
            if (k == pause_at)
                settle();
            if (k < cur_w * cur_h)
            begin
                if (noisy && $urandom_range(0, 31) == 0)
                    send_beat(pick_height(), 1'b1);
                send_beat(pick_height(), 1'b0);
            end
            else
                send_beat(pick_height(), !(noisy && $urandom_range(0, 3) == 0));
            fed_items++;
        end
    endtask

    // Result side: a random stall ahead of each beat, burst stretches with
    // ready held high, and one long hold-off when the stimulus asks for it.
    initial
    begin : result_sink
        int stall;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 99) == 0)
                sink_burst = !sink_burst;
            stall = pick_gap(sink_burst);
            if (hold_results)
            begin
                hold_results = 1'b0;
                stall        = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
        end
    end

    initial
    begin : stimulus
        int                    frame_no;
        int                    stop;
        int                    pause_at;
        logic                  need_cfg;
        logic                  hold_frame;
        logic [CFG_DATA_W-1:0] wdata;
        logic [CFG_DATA_W-1:0] hdata;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset size (64 x 64): a few rows of random beats, then cut short
        // by the next register write.
        run_frame(200, 1'b1, -1);

        // --- directed ---
        // 3 x 3 of full-scale samples: corners exact, edges and center
        // saturate. One pad inside the grid, one real sample in the flush.
        configure(CFG_DATA_W'(3), CFG_DATA_W'(3), 1'b0);
        repeat (4) send_beat(TOP_HEIGHT, 1'b0);
        send_beat(BOTTOM_HEIGHT, 1'b1);
        repeat (5) send_beat(TOP_HEIGHT, 1'b0);
        send_beat('0, 1'b1);
        send_beat(BOTTOM_HEIGHT, 1'b0);
        repeat (2) send_beat('0, 1'b1);

        // single point, width with bits above its field set
        configure({2'b11, 11'd1}, CFG_DATA_W'(1), 1'b0);
        send_beat(BOTTOM_HEIGHT, 1'b0);
        repeat (2) send_beat('0, 1'b1);

        // zero width and height behave as one; spare index write is ignored
        configure(CFG_DATA_W'(0), CFG_DATA_W'(0), 1'b1);
        send_beat(16'h0001, 1'b0);
        repeat (2) send_beat('0, 1'b1);

        // two points: mean of -1 and 0 is minus a half, which rounds up to 0
        configure(CFG_DATA_W'(2), CFG_DATA_W'(1), 1'b0);
        send_beat(MINUS_ONE, 1'b0);
        send_beat('0, 1'b0);
        repeat (3) send_beat('0, 1'b1);

        // --- random frames ---
        // Mostly complete frames with random content; some noisy, some cut
        // short (which forces a restart by register write), some back to
        // back with no write so the end-of-frame wrap is exercised.
        fed_items = 0;
        frame_no  = 0;
        need_cfg  = 1'b1;
        while (fed_items < RANDOM_ITEMS)
        begin
            hold_frame = (frame_no == 4);
            if (need_cfg || hold_frame || $urandom_range(0, 2) != 0)
            begin
                if (hold_frame)
                begin
                    // wide enough that the hold-off backs the block up
                    wdata = CFG_DATA_W'(16);
                    hdata = CFG_DATA_W'(6);
                end
                else
                begin
                    wdata = pick_dim(24);
                    hdata = pick_dim(10);
                    if ($urandom_range(0, 7) == 0)
                        wdata[CFG_DATA_W-1:MAP_WIDTH_W] = '1;
                end
                configure(wdata, hdata, $urandom_range(0, 4) == 0);
            end
            stop = frame_items();
            if (!hold_frame && $urandom_range(0, 7) == 0)
                stop = $urandom_range(1, frame_items() - 1);
            need_cfg = (stop != frame_items());
            pause_at = -1;
            if (frame_no == 8 || $urandom_range(0, 9) == 0)
                pause_at = $urandom_range(0, stop - 1);
            if (hold_frame)
                hold_results = 1'b1;
            run_frame(stop, !hold_frame && $urandom_range(0, 3) == 0, pause_at);
            frame_no++;
        end

        // --- size limits ---
        // widest field value clamps to the line store depth
        configure(CFG_DATA_W'(2047), CFG_DATA_W'(1), 1'b0);
        run_frame(frame_items(), 1'b1, -1);
        // tallest field value clamps to the row limit; one column keeps it short
        configure(CFG_DATA_W'(1), CFG_DATA_W'(8191), 1'b0);
        run_frame(frame_items(), 1'b1, -1);

        settle();
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* sim.f */
hdl/bs3_pkg.sv
hdl/bs3_front.sv
hdl/bs3_window.sv
hdl/bs3_queue.sv
hdl/bs3_mean.sv
hdl/box_smooth_3x3.sv
hdl/bs3_chk.sv
tb/sv/box_smooth_3x3_check.sv
tb/sv/box_smooth_3x3_tb.sv
